>>> design/radix_digit_converter_assert.svh
// Assertion macros for the radix digit converter.
// Expects clk and rst_n in the scope where a macro is used.
`ifndef RADIX_DIGIT_CONVERTER_ASSERT_SVH
`define RADIX_DIGIT_CONVERTER_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define RDC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset
`define RDC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/rdc_pkg.sv
// Shared types, constants and helpers for the radix digit converter.
// No dependencies; imported by every module of the block but rdc_ram.
package rdc_pkg;

  // Sizes of the conversion
  localparam int MAX_DIGITS = 64;
  localparam int VALUE_BITS = 63;

  // Field widths
  localparam int VAL_W     = 63;
  localparam int BASE_W    = 5;
  localparam int CHAR_W    = 7;
  localparam int DIGIT_W   = 4;
  localparam int IN_DATA_W = ((VAL_W + BASE_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((CHAR_W + 7) / 8) * 8;

  // Derived counter widths
  localparam int CNT_W  = $clog2(MAX_DIGITS + 1);
  localparam int ADDR_W = $clog2(MAX_DIGITS);
  localparam int BIT_W  = $clog2(VALUE_BITS);

  // Radix limits and character bases
  localparam logic [BASE_W-1:0] BASE_MIN  = BASE_W'(2);
  localparam logic [BASE_W-1:0] BASE_MAX  = BASE_W'(16);
  localparam logic [CHAR_W-1:0] CHAR_ZERO = 7'h30;
  localparam logic [CHAR_W-1:0] CHAR_A    = 7'h41;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_STORE,
    ST_RD,
    ST_LOAD,
    ST_OUT
  } rdc_state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;       // take a new value and base
    logic div_step;   // one restoring division step
    logic store;      // write remainder as next digit
    logic rd;         // read next digit, most significant first
    logic load_digit; // fill output register from read data
    logic load_inv;   // fill output register with invalid result
  } rdc_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic base_ok;    // offered base lies in 2..16
    logic quo_zero;   // quotient has reached zero
    logic cnt_last;   // store about to fill the last slot
    logic cnt_zero;   // no digits left to emit
  } rdc_status_t;

  // Digit to upper-case ASCII
  function automatic logic [CHAR_W-1:0] char_of(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] c;
    if (d < DIGIT_W'(10)) begin
      c = CHAR_ZERO + CHAR_W'(d);
    end else begin
      c = CHAR_A + CHAR_W'(d - DIGIT_W'(10));
    end
    return c;
  endfunction

endpackage

>>> design/rdc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rdc_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> design/rdc_datapath.sv
// Datapath: serial restoring divider, digit count, digit RAM, output register.
// Depends on rdc_pkg and rdc_ram.
module rdc_datapath
  import rdc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  rdc_cmd_t          cmd,
  output rdc_status_t       status,
  input  logic [VAL_W-1:0]  in_value,
  input  logic [BASE_W-1:0] in_base,
  output logic [CHAR_W-1:0] out_char,
  output logic              out_last,
  output logic              out_invalid
);

  logic [VALUE_BITS-1:0] val_r, val_nxt;
  logic [BASE_W-1:0]     base_r;
  logic [DIGIT_W-1:0]    rem_r, rem_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [CHAR_W-1:0]     char_r;
  logic                  last_r;
  logic                  inv_r;
  logic [BASE_W-1:0]     shifted;
  logic [BASE_W-1:0]     diff;
  logic                  q_bit;
  logic [DIGIT_W-1:0]    rd_data;
  logic [ADDR_W-1:0]     rd_addr;

  // One division step: bring in the next dividend bit, subtract if it fits
  always_comb begin
    shifted = {rem_r, val_r[VALUE_BITS-1]};
    diff    = shifted - base_r;
    q_bit   = (shifted >= base_r);
  end

  assign rd_addr = ADDR_W'(cnt_r - CNT_W'(1));

  // Next value of dividend, remainder and digit count
  always_comb begin
    val_nxt = val_r;
    rem_nxt = rem_r;
    cnt_nxt = cnt_r;
    priority if (cmd.load) begin
      val_nxt = in_value[VALUE_BITS-1:0];
      rem_nxt = '0;
      cnt_nxt = '0;
    end else if (cmd.div_step) begin
      val_nxt = {val_r[VALUE_BITS-2:0], q_bit};
      rem_nxt = q_bit ? diff[DIGIT_W-1:0] : shifted[DIGIT_W-1:0];
    end else if (cmd.store) begin
      rem_nxt = '0;
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (cmd.rd) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end else begin
      // hold
      cnt_nxt = cnt_r;
    end
  end

  // Count is control state; the rest is payload
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
    rem_r <= rem_nxt;
    if (cmd.load) begin
      base_r <= in_base;
    end
  end

  // Digit store
  rdc_ram #(
    .WIDTH (DIGIT_W),
    .DEPTH (MAX_DIGITS)
  ) u_store (
    .clk   (clk),
    .we    (cmd.store),
    .waddr (cnt_r[ADDR_W-1:0]),
    .wdata (rem_r),
    .re    (cmd.rd),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.load_inv) begin
      char_r <= '0;
      last_r <= 1'b1;
      inv_r  <= 1'b1;
    end else if (cmd.load_digit) begin
      char_r <= char_of(rd_data);
      last_r <= (cnt_r == '0);
      inv_r  <= 1'b0;
    end
  end

  assign out_char    = char_r;
  assign out_last    = last_r;
  assign out_invalid = inv_r;

  // Status to controller
  always_comb begin
    status.base_ok  = (in_base >= BASE_MIN) && (in_base <= BASE_MAX);
    status.quo_zero = (val_r == '0);
    status.cnt_last = (cnt_r == CNT_W'(MAX_DIGITS - 1));
    status.cnt_zero = (cnt_r == '0);
  end

endmodule

>>> design/rdc_ctrl.sv
// Controller: sequences division, digit storage and emission.
// Depends on rdc_pkg.
module rdc_ctrl
  import rdc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  output logic        out_tvalid,
  input  logic        out_tready,
  input  rdc_status_t status,
  output rdc_cmd_t    cmd
);

  rdc_state_t       state_r, state_nxt;
  logic [BIT_W-1:0] bit_r, bit_nxt;

  // State and bit counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      bit_r   <= '0;
    end else begin
      state_r <= state_nxt;
      bit_r   <= bit_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt  = state_r;
    bit_nxt    = bit_r;
    cmd        = '0;
    in_tready  = 1'b0;
    out_tvalid = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          if (status.base_ok) begin
            cmd.load  = 1'b1;
            bit_nxt   = BIT_W'(VALUE_BITS - 1);
            state_nxt = ST_DIV;
          end else begin
            cmd.load_inv = 1'b1;
            state_nxt    = ST_OUT;
          end
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        bit_nxt      = bit_r - BIT_W'(1);
        if (bit_r == '0) begin
          state_nxt = ST_STORE;
        end
      end
      ST_STORE: begin
        cmd.store = 1'b1;
        if (status.quo_zero || status.cnt_last) begin
          state_nxt = ST_RD;
        end else begin
          bit_nxt   = BIT_W'(VALUE_BITS - 1);
          state_nxt = ST_DIV;
        end
      end
      ST_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        cmd.load_digit = 1'b1;
        state_nxt      = ST_OUT;
      end
      ST_OUT: begin
        out_tvalid = 1'b1;
        if (out_tready) begin
          state_nxt = status.cnt_zero ? ST_IDLE : ST_RD;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

>>> design/radix_digit_converter.sv
// Channel | dir | handshake             | payload
// in_     | in  | in_tvalid/in_tready   | tdata: value[62:0], base[67:63]
// out_    | out | out_tvalid/out_tready | tdata: digit_char[6:0]; tlast; tuser: invalid
//
// One item at a time. For each digit a one-bit-per-cycle restoring divider runs
// VALUE_BITS steps, then the remainder goes to the digit RAM. Each digit is emitted
// by a RAM read, an output load and the beat, which waits for out_tready; a bad
// base skips division and goes straight to a single invalid beat.
// Reset is synchronous on rst_n and returns the controller to idle; digit RAM is
// not cleared. A stalled output beat holds everything until taken.
// Top level of the radix digit converter; depends on rdc_pkg, rdc_ctrl,
// rdc_datapath, rdc_ram and radix_digit_converter_assert.svh.
`include "radix_digit_converter_assert.svh"

module radix_digit_converter
  import rdc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // value[62:0], base[67:63], zero pad
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // digit_char[6:0], zero pad
  output logic                  out_tlast,
  output logic                  out_tuser   // invalid
);

  rdc_cmd_t          cmd;
  rdc_status_t       status;
  logic [CHAR_W-1:0] digit_char;
  logic              bad_in_beat;

  rdc_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .status     (status),
    .cmd        (cmd)
  );

  rdc_datapath u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .status      (status),
    .in_value    (in_tdata[VAL_W-1:0]),
    .in_base     (in_tdata[VAL_W+BASE_W-1:VAL_W]),
    .out_char    (digit_char),
    .out_last    (out_tlast),
    .out_invalid (out_tuser)
  );

  assign out_tdata = OUT_DATA_W'(digit_char);

  // Input beat whose base lies outside 2..16
  assign bad_in_beat = in_tvalid && in_tready && !status.base_ok;

  // Checks
  `RDC_ASSERT_IMP(a_no_overlap, out_tvalid, !in_tready, "input taken while a beat waits")
  `RDC_ASSERT_IMP(a_inv_last, out_tvalid && out_tuser, out_tlast, "invalid beat not last")
  `RDC_ASSERT_NXT(a_bad_base, bad_in_beat, out_tvalid && out_tuser, "bad base not flagged")
  `RDC_ASSERT_IMP(a_rd_nonempty, cmd.rd, !status.cnt_zero, "digit read with empty store")

endmodule

>>> tb/sv/radix_digit_converter_tb.sv
// Self-checking testbench for radix_digit_converter: integer to base-N ASCII digits.
// Depends on rdc_pkg and the radix_digit_converter RTL; predicts each digit beat itself.
module radix_digit_converter_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rdc_pkg::*;

  localparam int CYCLE_LIMIT  = 5_000_000;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 300;
  localparam int REPORT_MAX   = 10;
  localparam int DIGIT_BASE_TEN = 10;

  // One expected output beat
  typedef struct packed {
    logic [CHAR_W-1:0] digit_char;
    logic              last;
    logic              invalid;
  } char_beat_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;   // value[62:0], base[67:63], zero pad
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;       // digit_char[6:0], zero pad
  logic                  out_tlast;
  logic                  out_tuser;       // invalid

  char_beat_t expected_chars[$];
  int         mismatch_cnt = 0;
  int         cycle_cnt = 0;
  logic       steady = 1'b0;     // no random gaps are picked on either side while set
  logic       hold_start = 1'b0;
  int         hold_left = 0;
  int         rx_gap = 0;

  radix_digit_converter dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Mostly short gaps, a few long ones
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 40) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Divide down to digits, then queue them most significant first
  function automatic void predict_digits(input logic [VAL_W-1:0] value,
                                         input logic [BASE_W-1:0] base);
    logic [DIGIT_W-1:0] digits [MAX_DIGITS];
    logic [VAL_W-1:0]   quo;
    logic [VAL_W-1:0]   radix;
    logic [DIGIT_W-1:0] d;
    char_beat_t         beat;
    int                 n;
    if (base < BASE_MIN || base > BASE_MAX) begin
      beat.digit_char = '0;
      beat.last       = 1'b1;
      beat.invalid    = 1'b1;
      expected_chars.push_back(beat);
      return;
    end
    quo   = value;
    radix = VAL_W'(base);
    n     = 0;
    do begin
      digits[n] = DIGIT_W'(quo % radix);
      n++;
      quo = quo / radix;
    end while (quo != '0 && n < MAX_DIGITS);
    for (int i = n - 1; i >= 0; i--) begin
      d = digits[i];
      beat.digit_char = (d < DIGIT_BASE_TEN) ? CHAR_ZERO + CHAR_W'(d)
                                             : CHAR_A + CHAR_W'(d - DIGIT_BASE_TEN);
      beat.last       = (i == 0);
      beat.invalid    = 1'b0;
      expected_chars.push_back(beat);
    end
  endfunction

  // Offer one item and hold it until the beat is taken
  task automatic send_item(input logic [VAL_W-1:0] value, input logic [BASE_W-1:0] base);
    int gap;
    gap = steady ? 0 : pick_gap();
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= IN_DATA_W'({base, value});
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_digits(value, base);
  endtask

  task automatic send_random_item();
    logic [63:0]       raw;
    logic [VAL_W-1:0]  value;
    logic [BASE_W-1:0] base;
    int                nbits;
    raw   = {$urandom(), $urandom()};
    nbits = $urandom_range(0, VAL_W);
    value = raw[VAL_W-1:0];
    if (nbits < VAL_W) value = value & ((VAL_W'(1) << nbits) - VAL_W'(1));
    // Mostly legal radices, now and then anything the field holds
    if ($urandom_range(0, 9) == 0) base = BASE_W'($urandom_range(0, 31));
    else base = BASE_W'($urandom_range(2, 16));
    send_item(value, base);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (expected_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic test_zero_and_extremes();
    send_item('0, 5'd2);
    send_item('0, 5'd16);
    send_item('1, 5'd2);
    send_item('1, 5'd16);
    send_item('1, 5'd10);
    send_item(VAL_W'(1), 5'd2);
  endtask

  task automatic test_invalid_bases();
    send_item('1, 5'd0);
    send_item(VAL_W'(7), 5'd1);
    send_item('0, 5'd17);
    send_item('1, 5'd31);
  endtask

  // Same value in every legal radix; base 16 shows every hex digit but 0
  task automatic test_every_base();
    for (int b = 2; b <= 16; b++) send_item(63'h0123_4567_89AB_CDEF, BASE_W'(b));
  endtask

  // Stall the output long enough that the input backs up
  task automatic test_output_backpressure();
    steady     <= 1'b1;
    hold_start <= 1'b1;
    @(posedge clk);
    hold_start <= 1'b0;
    for (int i = 0; i < 4; i++) send_item(VAL_W'($urandom_range(0, 4095)), 5'd16);
    send_item(VAL_W'($urandom_range(0, 255)), 5'd2);
    steady <= 1'b0;
  endtask

  task automatic test_back_to_back();
    steady <= 1'b1;
    for (int i = 0; i < 10; i++) send_random_item();
    steady <= 1'b0;
  endtask

  task automatic test_random_items();
    for (int i = 0; i < 80; i++) send_random_item();
  endtask

  // Long hold counter for the backpressure test
  always @(posedge clk) begin
    if (hold_start) hold_left <= HOLD_CYCLES;
    else if (hold_left != 0) hold_left <= hold_left - 1;
  end

  // Drive ready with random stalls
  always @(posedge clk) begin
    if (hold_start || hold_left != 0) begin
      out_tready <= 1'b0;
    end else if (rx_gap != 0) begin
      out_tready <= 1'b0;
      rx_gap     <= rx_gap - 1;
    end else begin
      out_tready <= 1'b1;
      if (!steady && $urandom_range(0, 2) == 0) rx_gap <= pick_gap();
    end
  end

  task automatic flag_beat(input string why, input char_beat_t want);
    mismatch_cnt++;
    if (mismatch_cnt <= REPORT_MAX)
      $display("%0t: %s: expected char=%h last=%b invalid=%b, got data=%h last=%b invalid=%b",
               $realtime, why, want.digit_char, want.last, want.invalid,
               out_tdata, out_tlast, out_tuser);
  endtask

  // Compare each output beat with the oldest expectation
  always @(posedge clk) begin
    char_beat_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_chars.size() == 0) begin
        flag_beat("unexpected beat", '0);
      end else begin
        want = expected_chars.pop_front();
        if (out_tdata != OUT_DATA_W'(want.digit_char) || out_tlast != want.last ||
            out_tuser != want.invalid)
          flag_beat("beat mismatch", want);
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_zero_and_extremes();
    test_invalid_bases();
    test_every_base();
    test_output_backpressure();
    test_back_to_back();
    test_random_items();
    wait_drained();
    if (mismatch_cnt == 0 && expected_chars.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
